>>> design/tmtc_pkg.sv
package tmtc_pkg;

  localparam int DefaultMaxEvents = 64;
  localparam logic [17:0] DefaultTempoReset = 18'd30720;
  localparam logic [15:0] TicksPerBeatReset = 16'd480;

  // Microseconds per minute in Q.8: 60 * 1000000 * 256.
  localparam logic [33:0] UsPerMinQ8 = 34'd15360000000;
  localparam logic signed [63:0] SatLim = 64'sd1152921504606846976;
  localparam logic signed [63:0] Max48 = 64'sd140737488355327;
  localparam logic signed [63:0] Min48 = -64'sd140737488355328;
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  localparam logic [2:0] ReqInsert = 3'd0;
  localparam logic [2:0] ReqDelete = 3'd1;
  localparam logic [2:0] ReqTempo = 3'd2;
  localparam logic [2:0] ReqTickToTime = 3'd3;
  localparam logic [2:0] ReqTimeToTick = 3'd4;

  localparam logic CfgDefaultTempo = 1'b0;
  localparam logic CfgTicksPerBeat = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic signed [31:0] tick;
    logic signed [31:0] end_tick;
    logic [17:0] tempo_value;
    logic signed [47:0] time_in;
  } tmtc_in_t;

  typedef struct packed {
    logic [17:0] tempo_out;
    logic signed [47:0] time_out;
    logic signed [31:0] tick_out;
    logic status;
  } tmtc_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL,
    ST_DEL_WR,
    ST_CONV_CHK,
    ST_CONV_RD,
    ST_CONV_EV,
    ST_SEG_WAIT,
    ST_SEG_DONE,
    ST_FINAL,
    ST_FIN_WAIT,
    ST_OUT
  } tmtc_state_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SatLim)) sat_add = SatLim;
    else if (s < -65'(SatLim)) sat_add = -SatLim;
    else sat_add = s[63:0];
  endfunction

endpackage

>>> design/tmtc_muldiv.sv
// Bit-serial min(floor(a*b/d), cap) with the sign taken from the neg input.
// Multiply by shift and add, then restoring division of the 128-bit product.
module tmtc_muldiv (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic neg,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] d,
  output logic busy,
  output logic signed [63:0] res
);
  import tmtc_pkg::*;

  logic [1:0] ph_r, ph_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [127:0] prod_r, prod_nxt;
  logic [63:0] mcand_r, mcand_nxt, mplier_r, mplier_nxt, d_r;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic over_r, over_nxt, neg_r;
  logic signed [63:0] res_r, res_nxt;
  logic [64:0] rsh;
  logic [63:0] qq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 2'd0;
    end else begin
      ph_r <= ph_nxt;
    end
    cnt_r <= cnt_nxt;
    prod_r <= prod_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    over_r <= over_nxt;
    res_r <= res_nxt;
    if (start) begin
      d_r <= d;
      neg_r <= neg;
    end
  end

  always_comb begin
    ph_nxt = ph_r;
    cnt_nxt = cnt_r;
    prod_nxt = prod_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    over_nxt = over_r;
    res_nxt = res_r;
    rsh = {rem_r[63:0], prod_r[127]};
    qq = '0;
    unique case (ph_r)
      2'd0: begin
        if (start) begin
          ph_nxt = 2'd1;
          cnt_nxt = '0;
          prod_nxt = '0;
          mcand_nxt = a;
          mplier_nxt = b;
        end
      end
      2'd1: begin
        // One multiplier bit per cycle, most significant first.
        prod_nxt = {prod_r[126:0], 1'b0} + (mplier_r[63] ? {64'd0, mcand_r} : 128'd0);
        mplier_nxt = {mplier_r[62:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          ph_nxt = 2'd2;
          cnt_nxt = '0;
          rem_nxt = '0;
          q_nxt = '0;
          over_nxt = 1'b0;
        end
      end
      2'd2: begin
        if (q_r[63]) over_nxt = 1'b1;
        qq = {q_r[62:0], 1'b0};
        if (rsh >= {1'b0, d_r}) begin
          rem_nxt = rsh - {1'b0, d_r};
          qq[0] = 1'b1;
        end else begin
          rem_nxt = rsh;
        end
        q_nxt = qq;
        prod_nxt = {prod_r[126:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          ph_nxt = 2'd3;
        end
      end
      default: begin
        if (over_r || q_r > 64'(SatLim)) res_nxt = neg_r ? -SatLim : SatLim;
        else res_nxt = neg_r ? -$signed(q_r) : $signed(q_r);
        ph_nxt = 2'd0;
      end
    endcase
  end

  assign busy = (ph_r != 2'd0) || start;
  assign res = res_r;

endmodule

>>> design/tempo_map_time_converter.sv
// Channel   | Ports                          | Transfer when
// ----------+--------------------------------+-------------------------
// request   | in_valid, in_ready, in_data    | in_valid && in_ready
// result    | out_valid, out_ready, out_data | out_valid && out_ready
// config    | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// One request at a time. Lookup, insert and delete walk the event table one
// entry at a time through a single-port memory. A conversion runs one bit-serial
// multiply-divide per segment and one for the remainder. Reset is synchronous,
// empties the table and restores the register defaults. A stalled result waits
// in the output register while the next request is taken.
module tempo_map_time_converter #(
  parameter int MaxEvents = tmtc_pkg::DefaultMaxEvents
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tmtc_pkg::tmtc_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output tmtc_pkg::tmtc_out_t out_data,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [17:0] cfg_wdata
);
  import tmtc_pkg::*;

  localparam int AW = (MaxEvents > 1) ? $clog2(MaxEvents) : 1;
  localparam int CW = $clog2(MaxEvents + 1);

  // Tick and tempo live side by side in one memory word.
  logic [49:0] mem [MaxEvents];
  logic [49:0] rd_q;
  logic [AW-1:0] addr;
  logic we;
  logic [49:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  logic [17:0] dtempo_r;
  logic [15:0] tpb_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  tmtc_state_t st_r, st_nxt;
  tmtc_in_t req_r;
  logic have_r, have_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [17:0] tempo_r, tempo_nxt;
  logic signed [63:0] acc_r, acc_nxt, cur_r, cur_nxt;
  logic [49:0] hold_r, hold_nxt;
  logic status_r, status_nxt, match_r, match_nxt;
  tmtc_out_t outq_r, outq_nxt;
  logic out_valid_r, out_valid_nxt;

  logic md_start, md_neg, md_busy;
  logic [63:0] md_a, md_b, md_d;
  logic signed [63:0] md_res;

  tmtc_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start), .neg(md_neg),
    .a(md_a), .b(md_b), .d(md_d), .busy(md_busy), .res(md_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtempo_r <= DefaultTempoReset;
      tpb_r <= TicksPerBeatReset;
      cnt_r <= '0;
      st_r <= ST_IDLE;
      have_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgDefaultTempo) dtempo_r <= cfg_wdata;
        else tpb_r <= cfg_wdata[15:0];
      end
      cnt_r <= cnt_nxt;
      st_r <= st_nxt;
      have_r <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && in_ready) req_r <= in_data;
    i_r <= i_nxt;
    j_r <= j_nxt;
    tempo_r <= tempo_nxt;
    acc_r <= acc_nxt;
    cur_r <= cur_nxt;
    hold_r <= hold_nxt;
    status_r <= status_nxt;
    match_r <= match_nxt;
    outq_r <= outq_nxt;
  end

  logic signed [31:0] etk;
  logic [17:0] etp;
  logic signed [63:0] len, lim;
  logic [15:0] tpbe;
  logic [17:0] tme;
  logic [33:0] scale;
  logic conv_t2t;

  assign in_ready = !have_r;
  assign out_valid = out_valid_r;
  assign out_data = outq_r;
  assign etk = rd_q[49:18];
  assign etp = rd_q[17:0];
  // A zero tempo or timebase counts as one in the arithmetic.
  assign tpbe = (tpb_r == '0) ? 16'd1 : tpb_r;
  assign tme = (tempo_r == '0) ? 18'd1 : tempo_r;
  assign scale = tpbe * tme;
  assign conv_t2t = (req_r.req_type == ReqTimeToTick);

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    have_nxt = have_r;
    i_nxt = i_r;
    j_nxt = j_r;
    tempo_nxt = tempo_r;
    acc_nxt = acc_r;
    cur_nxt = cur_r;
    hold_nxt = hold_r;
    status_nxt = status_r;
    match_nxt = match_r;
    outq_nxt = outq_r;
    out_valid_nxt = out_valid_r;
    addr = i_r[AW-1:0];
    we = 1'b0;
    wdata = {req_r.tick, req_r.tempo_value};
    md_start = 1'b0;
    md_neg = 1'b0;
    md_a = '0;
    md_b = '0;
    md_d = '0;
    len = '0;
    lim = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (in_valid && !have_r) have_nxt = 1'b1;

    unique case (st_r)
      ST_IDLE: begin
        if (have_r) begin
          i_nxt = '0;
          j_nxt = '0;
          tempo_nxt = dtempo_r;
          acc_nxt = '0;
          cur_nxt = '0;
          status_nxt = 1'b0;
          match_nxt = 1'b0;
          unique case (req_r.req_type)
            ReqInsert, ReqTempo: st_nxt = ST_SCAN_RD;
            ReqDelete: st_nxt = ST_DEL_RD;
            ReqTickToTime, ReqTimeToTick: st_nxt = ST_CONV_CHK;
            default: st_nxt = ST_OUT;
          endcase
        end
      end
      // Find the first entry above the request tick.
      ST_SCAN_RD: begin
        st_nxt = (i_r == cnt_r) ? ST_INS_RD : ST_SCAN;
        if (i_r == cnt_r && req_r.req_type != ReqInsert) st_nxt = ST_OUT;
      end
      ST_SCAN: begin
        if (etk <= req_r.tick) begin
          tempo_nxt = etp;
          match_nxt = (etk == req_r.tick);
          i_nxt = i_r + 1'b1;
          st_nxt = ST_SCAN_RD;
        end else begin
          st_nxt = (req_r.req_type == ReqInsert) ? ST_INS_RD : ST_OUT;
        end
      end
      // Insert: overwrite, refuse, or shift entries up from the top.
      ST_INS_RD: begin
        if (match_r) begin
          addr = AW'(i_r - 1'b1);
          we = 1'b1;
          st_nxt = ST_OUT;
        end else if (cnt_r >= CW'(MaxEvents)) begin
          status_nxt = 1'b1;
          st_nxt = ST_OUT;
        end else begin
          j_nxt = cnt_r;
          if (cnt_r == i_r) begin
            addr = i_r[AW-1:0];
            we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            st_nxt = ST_OUT;
          end else begin
            addr = AW'(cnt_r - 1'b1);
            st_nxt = ST_INS_WR;
          end
        end
      end
      ST_INS_WR: begin
        addr = j_r[AW-1:0];
        we = 1'b1;
        wdata = rd_q;
        j_nxt = j_r - 1'b1;
        // Once the gap has reached its slot the new event goes in; otherwise
        // the next lower entry is read in the following cycle.
        st_nxt = (j_r - 1'b1 == i_r) ? ST_DEL_WR : ST_DEL_RD;
      end
      // Delete compacts in place; ST_DEL_RD also reads for the insert shift, and ST_DEL_WR ends an insert.
      ST_DEL_RD: begin
        if (req_r.req_type == ReqInsert) begin
          addr = AW'(j_r - 1'b1);
          st_nxt = ST_INS_WR;
        end else if (i_r == cnt_r) begin
          cnt_nxt = j_r;
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_DEL;
        end
      end
      ST_DEL: begin
        i_nxt = i_r + 1'b1;
        st_nxt = ST_DEL_RD;
        if (!(req_r.tick <= etk && etk <= req_r.end_tick)) begin
          addr = j_r[AW-1:0];
          we = 1'b1;
          wdata = rd_q;
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DEL_WR: begin
        addr = i_r[AW-1:0];
        we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        st_nxt = ST_OUT;
      end
      ST_CONV_CHK: begin
        if ((conv_t2t ? req_r.time_in < 0 : req_r.tick < 0) || cnt_r == '0) begin
          st_nxt = ST_FINAL;
          i_nxt = cnt_r;
        end else begin
          st_nxt = ST_CONV_RD;
        end
      end
      ST_CONV_RD: begin
        st_nxt = (i_r == cnt_r) ? ST_FINAL : ST_CONV_EV;
      end
      ST_CONV_EV: begin
        if (!conv_t2t && req_r.tick < etk) begin
          st_nxt = ST_FINAL;
        end else begin
          hold_nxt = rd_q;
          len = 64'(etk) - cur_r;
          md_start = 1'b1;
          md_neg = len < 0;
          md_a = len < 0 ? 64'(-len) : 64'(len);
          md_b = 64'(UsPerMinQ8);
          md_d = 64'(scale);
          st_nxt = ST_SEG_WAIT;
        end
      end
      ST_SEG_WAIT: begin
        if (!md_busy) st_nxt = ST_SEG_DONE;
      end
      ST_SEG_DONE: begin
        if (conv_t2t && 64'(req_r.time_in) < sat_add(acc_r, md_res)) begin
          st_nxt = ST_FINAL;
        end else begin
          acc_nxt = sat_add(acc_r, md_res);
          cur_nxt = 64'($signed(hold_r[49:18]));
          tempo_nxt = hold_r[17:0];
          i_nxt = i_r + 1'b1;
          st_nxt = ST_CONV_RD;
        end
      end
      ST_FINAL: begin
        md_start = 1'b1;
        if (conv_t2t) begin
          len = sat_add(64'(req_r.time_in), -acc_r);
          md_a = len < 0 ? 64'(-len) : 64'(len);
          md_b = 64'(scale);
          md_d = 64'(UsPerMinQ8);
        end else begin
          len = 64'(req_r.tick) - cur_r;
          md_a = len < 0 ? 64'(-len) : 64'(len);
          md_b = 64'(UsPerMinQ8);
          md_d = 64'(scale);
        end
        md_neg = len < 0;
        st_nxt = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (!md_busy) begin
          if (conv_t2t) begin
            lim = sat_add(cur_r, md_res);
            acc_nxt = (lim > Max32) ? Max32 : (lim < Min32 ? Min32 : lim);
          end else begin
            lim = sat_add(acc_r, md_res);
            acc_nxt = (lim > Max48) ? Max48 : (lim < Min48 ? Min48 : lim);
          end
          st_nxt = ST_OUT;
        end
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          outq_nxt = '0;
          outq_nxt.status = status_r;
          if (req_r.req_type == ReqTempo) outq_nxt.tempo_out = tempo_r;
          if (req_r.req_type == ReqTickToTime) outq_nxt.time_out = acc_r[47:0];
          if (conv_t2t) outq_nxt.tick_out = acc_r[31:0];
          out_valid_nxt = 1'b1;
          have_nxt = 1'b0;
          st_nxt = ST_IDLE;
        end
      end
    endcase
  end

endmodule

>>> design/tmtc_checker.sv
module tmtc_assertions (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input tmtc_pkg::tmtc_out_t out_data
);
  import tmtc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.tick_out == '0 && out_data.time_out == '0)
    else $error("full status with conversion data");

endmodule

bind tempo_map_time_converter tmtc_assertions u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
